### rtl/uuid_text_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// uuid_text_parser_unit_assert.svh
// Assertion macros used by the UUID text parser unit RTL.
// ----------------------------------------------------------------------------
`ifndef UUID_TEXT_PARSER_UNIT_ASSERT_SVH
`define UUID_TEXT_PARSER_UNIT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define UTP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Antecedent implies consequent in the same cycle.
`define UTP_ASSERT_IMPLY(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle.
`define UTP_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/utp_pkg.sv
// ----------------------------------------------------------------------------
// utp_pkg
// Types, character codes and the hex decode for the UUID text parser.
// ----------------------------------------------------------------------------
package utp_pkg;

   localparam int unsigned DIGIT_W      = 6;
   localparam int unsigned WORD_W       = 64;
   localparam int unsigned DIGITS_TOTAL = 32;
   localparam int unsigned DIGITS_HIGH  = 16;

   // request kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [7:0] CH_OPEN  = 8'h7B;
   localparam logic [7:0] CH_CLOSE = 8'h7D;
   localparam logic [7:0] CH_DASH  = 8'h2D;

   localparam logic [DIGIT_W-1:0] DASH_POS_FIRST = DIGIT_W'(8);
   localparam logic [DIGIT_W-1:0] DASH_POS_A     = DIGIT_W'(12);
   localparam logic [DIGIT_W-1:0] DASH_POS_B     = DIGIT_W'(16);
   localparam logic [DIGIT_W-1:0] DASH_POS_C     = DIGIT_W'(20);
   localparam logic [DIGIT_W-1:0] DIGITS_FULL    = DIGIT_W'(DIGITS_TOTAL);
   localparam logic [DIGIT_W-1:0] DIGITS_SPLIT   = DIGIT_W'(DIGITS_HIGH);

   typedef struct packed {
      logic               started;
      logic               has_brace;
      logic               dash_mode;
      logic               dash_taken;
      logic [DIGIT_W-1:0] digits_seen;
      logic               brace_closed;
      logic               error_seen;
   } utp_flags_type;

   typedef struct packed {
      utp_flags_type flags;
      logic          shift_en;
      logic [3:0]    nibble;
   } utp_step_type;

   // bit 4 set: not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = {1'b0, 4'(c - 8'h61 + 8'd10)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b0, 4'(c - 8'h41 + 8'd10)};
      end
      return v;
   endfunction

endpackage

### rtl/utp_char_step.sv
// ----------------------------------------------------------------------------
// utp_char_step
// Next parser state for one string character.
// ----------------------------------------------------------------------------
module utp_char_step (
   input  utp_pkg::utp_flags_type cur,
   input  logic [7:0]             ch,
   output utp_pkg::utp_step_type  nxt
);
   import utp_pkg::*;

   logic [4:0] hexv;
   logic       dash_slot;

   assign hexv      = hex_value(ch);
   assign dash_slot = (cur.digits_seen == DASH_POS_A) || (cur.digits_seen == DASH_POS_B) ||
                      (cur.digits_seen == DASH_POS_C);

   always_comb begin
      nxt          = '0;
      nxt.flags    = cur;
      nxt.nibble   = hexv[3:0];
      nxt.shift_en = 1'b0;
      if (!cur.error_seen) begin
         nxt.flags.started = 1'b1;
         priority if (!cur.started && ch == CH_OPEN) begin
            nxt.flags.has_brace = 1'b1;
         end else if (cur.digits_seen >= DIGITS_FULL) begin
            // only a single closing brace may follow the digits
            if (cur.has_brace && !cur.brace_closed && ch == CH_CLOSE) begin
               nxt.flags.brace_closed = 1'b1;
            end else begin
               nxt.flags.error_seen = 1'b1;
            end
         end else if (cur.digits_seen == DASH_POS_FIRST && !cur.dash_taken &&
                      ch == CH_DASH) begin
            nxt.flags.dash_mode  = 1'b1;
            nxt.flags.dash_taken = 1'b1;
         end else if (cur.dash_mode && !cur.dash_taken && dash_slot) begin
            if (ch == CH_DASH) begin
               nxt.flags.dash_taken = 1'b1;
            end else begin
               nxt.flags.error_seen = 1'b1;
            end
         end else if (hexv[4]) begin
            nxt.flags.error_seen = 1'b1;
         end else begin
            nxt.shift_en          = 1'b1;
            nxt.flags.digits_seen = cur.digits_seen + DIGIT_W'(1);
            nxt.flags.dash_taken  = 1'b0;
         end
      end
   end

endmodule

### rtl/uuid_text_parser_unit.sv
// ----------------------------------------------------------------------------
// uuid_text_parser_unit: streaming UUID text parser, one character a request.
// Response path: an end request is held in the input register, then registered as the response.
// Throughput: one request a cycle; an end request waits while a response is held.
// Reset: synchronous; parser flags and both channel valids clear at once.
// ----------------------------------------------------------------------------
`include "uuid_text_parser_unit_assert.svh"

module uuid_text_parser_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic [7:0]                   req_character,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [utp_pkg::WORD_W-1:0]   rsp_uuid_high,
   output logic [utp_pkg::WORD_W-1:0]   rsp_uuid_low,
   output logic                         rsp_valid_res
);
   import utp_pkg::*;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic              in_kind_ff;
   logic [7:0]        in_char_ff;

   // parser state
   utp_flags_type     flags_ff, flags_in;
   logic [WORD_W-1:0] hi_ff, hi_in;
   logic [WORD_W-1:0] lo_ff, lo_in;

   // response register
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_hi_ff, out_lo_ff;
   logic              out_ok_ff;

   utp_step_type      step;
   logic              out_free;
   logic              advance;
   logic              take_req;
   logic              end_adv;
   logic              char_adv;
   logic              ok;

   utp_char_step u_step (
      .cur (flags_ff),
      .ch  (in_char_ff),
      .nxt (step)
   );

   // A character request never waits; an end request needs the response slot.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (in_kind_ff == KIND_CHAR || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;
   assign end_adv   = advance && in_kind_ff == KIND_END;
   assign char_adv  = advance && in_kind_ff == KIND_CHAR;

   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   // well formed: all digits, brace closed if opened, no error
   assign ok = !flags_ff.error_seen && flags_ff.started &&
               flags_ff.digits_seen == DIGITS_FULL &&
               (!flags_ff.has_brace || flags_ff.brace_closed);

   always_comb begin
      flags_in = flags_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      if (end_adv) begin
         flags_in = '0;
      end else if (char_adv) begin
         flags_in = step.flags;
         // digits 0..15 fill the high word, 16..31 the low word
         if (step.shift_en && flags_ff.digits_seen < DIGITS_SPLIT) begin
            hi_in = {hi_ff[WORD_W-5:0], step.nibble};
         end else if (step.shift_en) begin
            lo_in = {lo_ff[WORD_W-5:0], step.nibble};
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (end_adv) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         flags_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         flags_ff     <= flags_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: no reset; words are fully rewritten before any valid response
   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      if (take_req) begin
         in_kind_ff <= req_kind;
         in_char_ff <= req_character;
      end
      if (end_adv) begin
         out_hi_ff <= ok ? hi_ff : '0;
         out_lo_ff <= ok ? lo_ff : '0;
         out_ok_ff <= ok;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_uuid_high = out_hi_ff;
   assign rsp_uuid_low  = out_lo_ff;
   assign rsp_valid_res = out_ok_ff;

   `UTP_ASSERT_ALWAYS(a_digits_bound, flags_ff.digits_seen <= DIGITS_FULL, "digit count past 32")
   `UTP_ASSERT_IMPLY(a_close_needs_open, flags_ff.brace_closed,
      flags_ff.has_brace && flags_ff.digits_seen == DIGITS_FULL, "brace closed out of order")
   `UTP_ASSERT_IMPLY(a_bad_is_zero, rsp_valid && !rsp_valid_res,
      rsp_uuid_high == '0 && rsp_uuid_low == '0, "invalid response carries a value")
   `UTP_ASSERT_NEXT(a_end_clears, end_adv,
      !flags_ff.started && flags_ff.digits_seen == '0 && !flags_ff.error_seen,
      "parser state not cleared after end")
   `UTP_ASSERT_IMPLY(a_stall_needs_item, req_stall, in_valid_ff, "stall with empty input register")

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: UUID text parser
// Streams UUID text one character a request into the parser and checks each
// end-of-string response (value halves and valid flag) against a built-in
// parser model. Directed corner strings come first, then random braced,
// dashed, damaged and noise strings under varying sender and receiver gaps.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import utp_pkg::*;

   localparam int unsigned STUCK_LIMIT = 3000;  // cycles with no handshake at all
   localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int unsigned PHASE_ITEMS = 360;
   localparam int unsigned BURST_ENDS  = 50;

   typedef struct packed {
      logic       kind;
      logic [7:0] code;
   } parser_request_type;

   typedef struct packed {
      logic [WORD_W-1:0] high;
      logic [WORD_W-1:0] low;
      logic              ok;
   } uuid_result_type;

   // ways of spoiling a generated string
   typedef enum int unsigned {
      DAMAGE_NONE,
      DAMAGE_SWAP,
      DAMAGE_DROP,
      DAMAGE_ADD,
      DAMAGE_CUT,
      DAMAGE_TAIL
   } damage_type;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic              req_kind      = KIND_CHAR;
   logic [7:0]        req_character = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic [WORD_W-1:0] rsp_uuid_high;
   logic [WORD_W-1:0] rsp_uuid_low;
   logic              rsp_valid_res;

   parser_request_type pending_q[$];
   parser_request_type next_req;
   uuid_result_type    expected_uuids[$];
   uuid_result_type    want;

   int unsigned queued_count  = 0;
   int unsigned mismatches    = 0;
   int unsigned stuck_cycles  = 0;
   int unsigned send_gap_pct  = 0;
   int unsigned recv_gap_pct  = 0;
   int unsigned hold_token    = 0;
   int unsigned hold_seen     = 0;
   int unsigned hold_left     = 0;

   // parser model state
   logic              pr_started;
   logic              pr_brace;
   logic              pr_dashes;
   logic              pr_dash_taken;
   logic [DIGIT_W-1:0] pr_digits;
   logic              pr_closed;
   logic              pr_error;
   logic [WORD_W-1:0] pr_high;
   logic [WORD_W-1:0] pr_low;

   uuid_text_parser_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_character (req_character),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_uuid_high (rsp_uuid_high),
      .rsp_uuid_low  (rsp_uuid_low),
      .rsp_valid_res (rsp_valid_res)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------
   function automatic void clear_parser();
      pr_started    = 1'b0;
      pr_brace      = 1'b0;
      pr_dashes     = 1'b0;
      pr_dash_taken = 1'b0;
      pr_digits     = '0;
      pr_closed     = 1'b0;
      pr_error      = 1'b0;
      pr_high       = '0;
      pr_low        = '0;
   endfunction

   // bit 4 set: not a hex digit
   function automatic logic [4:0] nibble_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
      if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h57)};
      if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h37)};
      return 5'h10;
   endfunction

   function automatic void parse_char(logic [7:0] c);
      logic [4:0] nib;
      if (pr_error) return;
      if (!pr_started) begin
         pr_started = 1'b1;
         if (c == CH_OPEN) begin
            pr_brace = 1'b1;
            return;
         end
      end
      // all digits in: only a pending close brace may follow
      if (pr_digits >= DIGITS_FULL) begin
         if (pr_brace && !pr_closed && c == CH_CLOSE) pr_closed = 1'b1;
         else pr_error = 1'b1;
         return;
      end
      // a dash after the eighth digit selects dash mode
      if (pr_digits == DASH_POS_FIRST && !pr_dash_taken && c == CH_DASH) begin
         pr_dashes     = 1'b1;
         pr_dash_taken = 1'b1;
         return;
      end
      if (pr_dashes && !pr_dash_taken &&
          (pr_digits == DASH_POS_A || pr_digits == DASH_POS_B ||
           pr_digits == DASH_POS_C)) begin
         if (c == CH_DASH) pr_dash_taken = 1'b1;
         else pr_error = 1'b1;
         return;
      end
      nib = nibble_of(c);
      if (nib[4]) begin
         pr_error = 1'b1;
         return;
      end
      if (pr_digits < DIGITS_SPLIT) pr_high = {pr_high[WORD_W-5:0], nib[3:0]};
      else pr_low = {pr_low[WORD_W-5:0], nib[3:0]};
      pr_digits     = pr_digits + DIGIT_W'(1);
      pr_dash_taken = 1'b0;
   endfunction

   // end of string: queue the expected response and return to idle
   function automatic void close_uuid();
      uuid_result_type r;
      r.ok   = !pr_error && pr_started && pr_digits == DIGITS_FULL &&
               (!pr_brace || pr_closed);
      r.high = r.ok ? pr_high : '0;
      r.low  = r.ok ? pr_low  : '0;
      expected_uuids.push_back(r);
      clear_parser();
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offers pending requests, feeds accepted ones to the model
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_parser();
      end else begin
         if (req_valid && !req_stall) begin
            if (req_kind == KIND_CHAR) parse_char(req_character);
            else close_uuid();
         end
         // a stalled request holds its payload; otherwise load the next one
         if (!req_valid || !req_stall) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               next_req      = pending_q.pop_front();
               req_kind      <= next_req.kind;
               req_character <= next_req.code;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stall, plus a long hold-off on request of the sequencer
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_gap_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: compares each response with the oldest expectation
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                  logic [WORD_W-1:0] exp_val);
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, exp_val, $time);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
         else stuck_cycles <= stuck_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_uuids.size() == 0) begin
               report_mismatch("response with none expected", rsp_uuid_high, '0);
            end else begin
               want = expected_uuids.pop_front();
               if (rsp_uuid_high !== want.high)
                  report_mismatch("uuid_high", rsp_uuid_high, want.high);
               if (rsp_uuid_low !== want.low)
                  report_mismatch("uuid_low", rsp_uuid_low, want.low);
               if (rsp_valid_res !== want.ok)
                  report_mismatch("valid_res", WORD_W'(rsp_valid_res), WORD_W'(want.ok));
            end
         end
      end
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic push_req(logic kind, logic [7:0] code);
      pending_q.push_back('{kind: kind, code: code});
      queued_count++;
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
   endfunction

   // characters the parser treats specially, or anything at all
   function automatic logic [7:0] odd_char();
      unique case ($urandom_range(4))
         0:       return CH_DASH;
         1:       return CH_OPEN;
         2:       return CH_CLOSE;
         3:       return hex_char(4'($urandom_range(15)));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic queue_uuid(bit braced, bit dashed, damage_type damage);
      logic [7:0]  text[$];
      int unsigned pos;
      if (braced) text.push_back(CH_OPEN);
      for (int i = 0; i < DIGITS_TOTAL; i++) begin
         if (dashed && (i == 8 || i == 12 || i == 16 || i == 20)) text.push_back(CH_DASH);
         text.push_back(hex_char(4'($urandom_range(15))));
      end
      if (braced) text.push_back(CH_CLOSE);
      pos = $urandom_range(text.size() - 1);
      unique case (damage)
         DAMAGE_SWAP: text[pos] = odd_char();
         DAMAGE_DROP: text.delete(pos);
         DAMAGE_ADD:  text.insert(pos, odd_char());
         DAMAGE_CUT:  while (text.size() > pos) void'(text.pop_back());
         DAMAGE_TAIL: text.push_back(odd_char());
         default:     ;
      endcase
      foreach (text[i]) push_req(KIND_CHAR, text[i]);
      // the character of an end request is don't-care
      push_req(KIND_END, 8'($urandom_range(255)));
   endtask

   task automatic queue_noise();
      int unsigned n;
      n = $urandom_range(5);
      repeat (n) push_req(KIND_CHAR, 8'($urandom_range(255)));
      push_req(KIND_END, 8'($urandom_range(255)));
   endtask

   task automatic queue_phase(int unsigned target);
      int unsigned start;
      int unsigned pick;
      start = queued_count;
      while (queued_count - start < target) begin
         pick = $urandom_range(99);
         if (pick < 65)
            queue_uuid(1'($urandom_range(1)), 1'($urandom_range(1)), DAMAGE_NONE);
         else if (pick < 90)
            queue_uuid(1'($urandom_range(1)), 1'($urandom_range(1)),
                       damage_type'($urandom_range(DAMAGE_SWAP, DAMAGE_TAIL)));
         else
            queue_noise();
      end
   endtask

   // sender pauses until everything offered is taken and answered
   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid || expected_uuids.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [7:0] lone_chars[];
      lone_chars = '{CH_OPEN, CH_CLOSE, CH_DASH, 8'h39, 8'h2F, 8'h3A,
                     8'h40, 8'h47, 8'h60, 8'h66};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles often, receiver idles more
      send_gap_pct = 35;
      recv_gap_pct = 67;

      // directed: empty string, lone characters (all early ends), error then junk
      push_req(KIND_END, 8'h00);
      foreach (lone_chars[i]) begin
         push_req(KIND_CHAR, lone_chars[i]);
         push_req(KIND_END, 8'hFF);
      end
      push_req(KIND_CHAR, 8'h00);
      push_req(KIND_CHAR, 8'hFF);
      push_req(KIND_END, 8'h00);
      wait_drained();

      // receiver holds off while a burst of end requests backs up
      hold_token++;
      repeat (BURST_ENDS) push_req(KIND_END, 8'($urandom_range(255)));
      queue_uuid(1'b1, 1'b1, DAMAGE_NONE);
      wait_drained();
      queue_phase(PHASE_ITEMS);
      wait_drained();

      // phase two: roles swapped
      send_gap_pct = 67;
      recv_gap_pct = 35;
      queue_phase(PHASE_ITEMS);
      wait_drained();

      // phase three: full rate both sides
      send_gap_pct = 0;
      recv_gap_pct = 0;
      queue_phase(PHASE_ITEMS);
      wait_drained();

      // catch any stray response after the last expected one
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### uuid_text_parser_unit.f
+incdir+rtl
rtl/utp_pkg.sv
rtl/utp_char_step.sv
rtl/uuid_text_parser_unit.sv
tb/testbench.sv
